[hw/rtl/lph_pkg.sv]
// ----------------------------------------------------------------------------
// lph_pkg
// shared constants, mode codes and the integer mix rounds of the hash set
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int SLOT_CAP   = TABLE_SIZE - 1;

  localparam int VALUE_W = 32;
  localparam int LIMIT_W = 8;
  localparam int COUNT_W = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd255;

  // mix rounds: two hash steps per round
  localparam int             ROUND_W    = 2;
  localparam logic [ROUND_W-1:0] ROUND_FIRST = 2'd0;
  localparam logic [ROUND_W-1:0] ROUND_MID   = 2'd1;
  localparam logic [ROUND_W-1:0] ROUND_LAST  = 2'd2;

  localparam logic [31:0] MIX_C0 = 32'h7ed5_5d16;
  localparam logic [31:0] MIX_C1 = 32'hc761_c23c;
  localparam logic [31:0] MIX_C2 = 32'h1656_67b1;
  localparam logic [31:0] MIX_C3 = 32'hd3a2_646c;
  localparam logic [31:0] MIX_C4 = 32'hfd70_46c5;
  localparam logic [31:0] MIX_C5 = 32'hb55a_4f09;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_MEMBER = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  function automatic logic [31:0] mix_pair(input logic [31:0] v,
                                           input logic [ROUND_W-1:0] rnd);
    logic [31:0] a;
    logic [31:0] b;
    a = '0;
    b = '0;
    case (rnd)
      ROUND_FIRST: begin
        a = (v + MIX_C0) + (v << 12);
        b = (a ^ MIX_C1) ^ (a >> 19);
      end
      ROUND_MID: begin
        a = (v + MIX_C2) + (v << 5);
        b = (a + MIX_C3) ^ (a << 9);
      end
      default: begin
        a = (v + MIX_C4) + (v << 3);
        b = (a ^ MIX_C5) ^ (a >> 16);
      end
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/lph_ram.sv]
// ----------------------------------------------------------------------------
// lph_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lph_hash.sv]
// ----------------------------------------------------------------------------
// lph_hash
// iterative six-step integer mix, two steps per cycle over three rounds
// ----------------------------------------------------------------------------
module lph_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lph_pkg::VALUE_W-1:0] value_i,
  output logic                        done_o,
  output logic [lph_pkg::VALUE_W-1:0] hash_o
);

  logic [lph_pkg::VALUE_W-1:0] acc_q, acc_d;
  logic [lph_pkg::ROUND_W-1:0] rnd_q, rnd_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    rnd_d  = rnd_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = value_i;
      rnd_d  = lph_pkg::ROUND_FIRST;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = lph_pkg::mix_pair(acc_q, rnd_q);
      rnd_d = rnd_q + 1'b1;
      if (rnd_q == lph_pkg::ROUND_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= lph_pkg::ROUND_FIRST;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rnd_q  <= rnd_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign hash_o = acc_q;

endmodule

[hw/rtl/linear_probe_integer_hash_set.sv]
// ----------------------------------------------------------------------------
// linear_probe_integer_hash_set
// open-addressed set of 32-bit integers with linear probing over a slot ram
// ----------------------------------------------------------------------------
// clear, no-op and the value zero go from ST_IDLE straight to ST_FIN and then
//   to the output register; other words wait in ST_HASH on the three hash rounds,
//   then take one ram read (ST_READ) and one compare (ST_CMP) per probed slot
// one word in flight; the next word is taken while a result waits on the output
// reset: slot table reads empty at once (per-slot valid bits), limit 255
// ----------------------------------------------------------------------------
module linear_probe_integer_hash_set (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config
  input  logic                        cfg_we_i,
  input  logic [lph_pkg::LIMIT_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [lph_pkg::VALUE_W-1:0] value_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        answer_o,
  output logic                        table_full_o,
  output logic [lph_pkg::COUNT_W-1:0] element_count_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HASH = 5'b00010,
    ST_READ = 5'b00100,
    ST_CMP  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  localparam int SW = lph_pkg::SLOT_W;
  localparam int VW = lph_pkg::VALUE_W;

  state_e state_q, state_d;

  // latched word
  lph_pkg::mode_e mode_q, mode_d;
  logic [VW-1:0]  value_q, value_d;

  // probe position and step count
  logic [SW-1:0] pos_q, pos_d;
  logic [SW-1:0] steps_q, steps_d;

  // set state outside the ram
  logic [lph_pkg::TABLE_SIZE-1:0] valid_q, valid_d;
  logic [SW-1:0]                  count_q, count_d;
  logic                           zero_q, zero_d;
  logic [lph_pkg::LIMIT_W-1:0]    limit_q, limit_d;

  // pending result, waits in ST_FIN for the output register
  logic res_answer_q, res_answer_d;
  logic res_full_q, res_full_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic                        out_answer_q, out_answer_d;
  logic                        out_full_q, out_full_d;
  logic [lph_pkg::COUNT_W-1:0] out_count_q, out_count_d;

  logic          in_accept;
  logic          hash_start;
  logic          hash_done;
  logic [VW-1:0] hash_val;

  logic          ram_we;
  logic          ram_re;
  logic [VW-1:0] ram_rdata;
  logic [VW-1:0] slot_val;
  logic          at_limit;
  logic          out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // only nonzero adds and lookups need the table
  assign hash_start = in_accept && (value_i != '0) &&
                      ((mode_i == lph_pkg::MODE_ADD) || (mode_i == lph_pkg::MODE_MEMBER));

  lph_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .value_i (value_i),
    .done_o  (hash_done),
    .hash_o  (hash_val)
  );

  lph_ram #(
    .WIDTH (VW),
    .DEPTH (lph_pkg::TABLE_SIZE)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (value_q),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // a slot never written since reset or clear reads as empty
  assign slot_val = valid_q[pos_q] ? ram_rdata : '0;

  // effective limit is the smaller of the register and one below table size
  assign at_limit = (32'(count_q) >= 32'(limit_q)) ||
                    (32'(count_q) >= 32'(lph_pkg::SLOT_CAP));

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    value_d      = value_q;
    pos_d        = pos_q;
    steps_d      = steps_q;
    valid_d      = valid_q;
    count_d      = count_q;
    zero_d       = zero_q;
    limit_d      = limit_q;
    res_answer_d = res_answer_q;
    res_full_d   = res_full_q;
    out_valid_d  = out_valid_q;
    out_answer_d = out_answer_q;
    out_full_d   = out_full_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    if (cfg_we_i) begin
      limit_d = cfg_wdata_i;
    end

    // drain the output register
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mode_d       = lph_pkg::mode_e'(mode_i);
          value_d      = value_i;
          res_answer_d = 1'b0;
          res_full_d   = 1'b0;
          state_d      = ST_FIN;
          case (lph_pkg::mode_e'(mode_i))
            lph_pkg::MODE_ADD: begin
              if (value_i == '0) begin
                res_answer_d = !zero_q;
                zero_d       = 1'b1;
              end else begin
                state_d = ST_HASH;
              end
            end
            lph_pkg::MODE_MEMBER: begin
              if (value_i == '0) begin
                res_answer_d = zero_q;
              end else begin
                state_d = ST_HASH;
              end
            end
            lph_pkg::MODE_CLEAR: begin
              valid_d = '0;
              count_d = '0;
              zero_d  = 1'b0;
            end
            default: begin
              // no-op word: just report the count
            end
          endcase
        end
      end

      ST_HASH: begin
        if (hash_done) begin
          pos_d   = hash_val[SW-1:0];
          steps_d = '0;
          state_d = ST_READ;
        end
      end

      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_CMP;
      end

      ST_CMP: begin
        if (slot_val == value_q) begin
          // found: add reports not new, lookup reports present
          res_answer_d = (mode_q == lph_pkg::MODE_MEMBER);
          state_d      = ST_FIN;
        end else if (slot_val == '0) begin
          // empty slot ends the probe
          state_d = ST_FIN;
          if (mode_q == lph_pkg::MODE_ADD) begin
            if (at_limit) begin
              res_full_d = 1'b1;
            end else begin
              ram_we         = 1'b1;
              valid_d[pos_q] = 1'b1;
              count_d        = count_q + 1'b1;
              res_answer_d   = 1'b1;
            end
          end
        end else if (steps_q == '1) begin
          // whole table walked with no match and no empty slot
          res_full_d = (mode_q == lph_pkg::MODE_ADD);
          state_d    = ST_FIN;
        end else begin
          pos_d   = pos_q + 1'b1;
          steps_d = steps_q + 1'b1;
          state_d = ST_READ;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_answer_d = res_answer_q;
          out_full_d   = res_full_q;
          out_count_d  = lph_pkg::COUNT_W'(count_q) + lph_pkg::COUNT_W'(zero_q);
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      zero_q      <= 1'b0;
      limit_q     <= lph_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      zero_q      <= zero_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    value_q      <= value_d;
    pos_q        <= pos_d;
    steps_q      <= steps_d;
    res_answer_q <= res_answer_d;
    res_full_q   <= res_full_d;
    out_answer_q <= out_answer_d;
    out_full_q   <= out_full_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o     = out_valid_q;
  assign answer_o        = out_answer_q;
  assign table_full_o    = out_full_q;
  assign element_count_o = out_count_q;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the linear-probe integer hash set: a shadow copy of
// the slot table predicts every result, directed tests hit zero, duplicates,
// probe wrap and the entry limit, then random phases fill the table, also under
// sender idling and receiver back-pressure
// ----------------------------------------------------------------------------
module tb;
  import lph_pkg::*;

  // result word as it leaves the block
  typedef struct packed {
    logic               answer;
    logic               table_full;
    logic [COUNT_W-1:0] count;
  } result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [LIMIT_W-1:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         mode_i;
  logic [VALUE_W-1:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               answer_o;
  logic               table_full_o;
  logic [COUNT_W-1:0] element_count_o;

  // shadow copy of the set, updated as each word is accepted
  logic [VALUE_W-1:0] shadow_slots [TABLE_SIZE];
  int unsigned        shadow_stored;
  logic               shadow_zero;
  int unsigned        shadow_limit;

  result_t            expected_results [$];
  logic [VALUE_W-1:0] value_pool [$];
  int unsigned        mismatch_count;
  int unsigned        idle_pct;
  int unsigned        stall_pct;
  result_t            observed;

  linear_probe_integer_hash_set u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .answer_o       (answer_o),
    .table_full_o   (table_full_o),
    .element_count_o(element_count_o)
  );

  always #6 clk_i = ~clk_i;

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // six-step integer mix, masked down to a home slot
  function automatic logic [SLOT_W-1:0] home_slot(input logic [VALUE_W-1:0] v);
    logic [31:0] h;
    h = v;
    h = (h + MIX_C0) + (h << 12);
    h = (h ^ MIX_C1) ^ (h >> 19);
    h = (h + MIX_C2) + (h << 5);
    h = (h + MIX_C3) ^ (h << 9);
    h = (h + MIX_C4) + (h << 3);
    h = (h ^ MIX_C5) ^ (h >> 16);
    return h[SLOT_W-1:0];
  endfunction

  // random nonzero value, different from v, landing on the same home slot
  function automatic logic [VALUE_W-1:0] slot_partner(input logic [SLOT_W-1:0] slot,
                                                      input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] c;
    do c = $urandom; while (c == 0 || c == v || home_slot(c) != slot);
    return c;
  endfunction

  // applies one word to the shadow set and returns the result it must produce
  function automatic result_t hash_set_apply(input mode_e m, input logic [VALUE_W-1:0] v);
    result_t     r;
    int unsigned pos;
    int unsigned steps;
    int unsigned cap;
    int unsigned free_pos;
    bit          found;
    bit          have_free;
    r = '0;
    found = 0;
    have_free = 0;
    free_pos = 0;
    if ((m == MODE_ADD || m == MODE_MEMBER) && v != 0) begin
      // linear probe with wrap, never more than one lap
      pos = 32'(home_slot(v));
      for (steps = 0; steps < TABLE_SIZE && !found && !have_free; steps++) begin
        if (shadow_slots[pos] == v) begin
          found = 1;
        end else if (shadow_slots[pos] == 0) begin
          have_free = 1;
          free_pos = pos;
        end else begin
          pos = (pos + 1) % TABLE_SIZE;
        end
      end
    end
    cap = (shadow_limit < SLOT_CAP) ? shadow_limit : SLOT_CAP;
    case (m)
      MODE_ADD: begin
        if (v == 0) begin
          r.answer = !shadow_zero;
          shadow_zero = 1'b1;
        end else if (!found) begin
          if (shadow_stored >= cap || !have_free) begin
            r.table_full = 1'b1;
          end else begin
            shadow_slots[free_pos] = v;
            shadow_stored++;
            r.answer = 1'b1;
          end
        end
      end
      MODE_MEMBER: begin
        r.answer = (v == 0) ? shadow_zero : found;
      end
      MODE_CLEAR: begin
        foreach (shadow_slots[i]) shadow_slots[i] = '0;
        shadow_stored = 0;
        shadow_zero = 1'b0;
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(shadow_stored + 32'(shadow_zero));
    return r;
  endfunction

  // sends one word; entered and left at a falling edge, valid stays up between words unless the sender idles
  task automatic send_word(input mode_e m, input logic [VALUE_W-1:0] v);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(hash_set_apply(m, v));
    if (m == MODE_ADD && v != 0) begin
      if (value_pool.size() < 64) value_pool.push_back(v);
      else value_pool[$urandom_range(0, 63)] = v;
    end
    @(negedge clk_i);
  endtask

  // drops valid and waits until every expected word has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // limit register write, only ever issued with the block idle
  task automatic set_limit(input logic [LIMIT_W-1:0] lim);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    shadow_limit = 32'(lim);
  endtask

  // zero flag, extremes, duplicates, no-op and clear
  task automatic test_zero_and_extremes();
    send_word(MODE_MEMBER, 32'h0);
    send_word(MODE_ADD, 32'h0);
    send_word(MODE_ADD, 32'h0);
    send_word(MODE_MEMBER, 32'h0);
    send_word(MODE_ADD, 32'hffff_ffff);
    send_word(MODE_ADD, 32'h1);
    send_word(MODE_ADD, 32'hffff_ffff);
    send_word(MODE_MEMBER, 32'h1);
    send_word(MODE_MEMBER, 32'h2);
    send_word(MODE_NOP, 32'hffff_ffff);
    send_word(MODE_CLEAR, 32'h0);
    send_word(MODE_MEMBER, 32'hffff_ffff);
  endtask

  // collisions on the last slot force the probe to wrap to slot 0
  task automatic test_probe_wrap();
    logic [VALUE_W-1:0] top_a;
    logic [VALUE_W-1:0] top_b;
    logic [VALUE_W-1:0] low_a;
    top_a = slot_partner(SLOT_W'(TABLE_SIZE - 1), 32'h0);
    top_b = slot_partner(SLOT_W'(TABLE_SIZE - 1), top_a);
    low_a = slot_partner('0, 32'h0);
    send_word(MODE_ADD, top_a);
    send_word(MODE_ADD, top_b);
    send_word(MODE_MEMBER, top_b);
    send_word(MODE_ADD, low_a);
    send_word(MODE_MEMBER, low_a);
  endtask

  // limit of zero refuses every new nonzero value, limit of one allows a single one
  task automatic test_entry_limit();
    logic [VALUE_W-1:0] first_v;
    logic [VALUE_W-1:0] second_v;
    first_v  = $urandom | 32'h8000_0000;
    second_v = first_v ^ 32'h0000_5a5a;
    set_limit('0);
    send_word(MODE_ADD, first_v);
    send_word(MODE_ADD, 32'h0);
    send_word(MODE_MEMBER, first_v);
    send_word(MODE_CLEAR, 32'h0);
    set_limit(8'd1);
    send_word(MODE_ADD, first_v);
    send_word(MODE_ADD, second_v);
    send_word(MODE_ADD, first_v);
  endtask

  // value mix: zero, earlier adds, colliding values, extremes, small values, else fresh
  function automatic logic [VALUE_W-1:0] pick_value(input int unsigned reuse_pct);
    int unsigned        r;
    logic [VALUE_W-1:0] v;
    if ($urandom_range(0, 99) >= reuse_pct || value_pool.size() == 0) return $urandom;
    r = $urandom_range(0, 9);
    v = value_pool[$urandom_range(0, value_pool.size() - 1)];
    if (r < 2) return '0;
    if (r < 6) return v;
    if (r < 8) return slot_partner(home_slot(v), v);
    if (r < 9) return 32'hffff_ffff - $urandom_range(0, 3);
    return $urandom_range(1, 16);
  endfunction

  // one random phase with its own limit and handshake pressure
  task automatic test_random_phase(input int unsigned words, input logic [LIMIT_W-1:0] lim,
                                   input int unsigned send_idle, input int unsigned recv_stall,
                                   input int unsigned add_pct, input int unsigned clear_pct,
                                   input int unsigned reuse_pct);
    int unsigned r;
    set_limit(lim);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    repeat (words) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) send_word(MODE_ADD, pick_value(reuse_pct));
      else if (r < 100 - clear_pct - 2) send_word(MODE_MEMBER, pick_value(reuse_pct + 30));
      else if (r < 100 - clear_pct) send_word(MODE_NOP, $urandom);
      else send_word(MODE_CLEAR, $urandom);
    end
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // compares each returned word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      observed = '{answer_o, table_full_o, element_count_o};
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected word answer=%0b full=%0b count=%0d", $time,
                   observed.answer, observed.table_full, observed.count);
        mismatch_count++;
      end else begin
        if (observed !== expected_results[0]) begin
          if (mismatch_count < 10)
            $display("%0t: mismatch exp answer=%0b full=%0b count=%0d, got %0b %0b %0d",
                     $time, expected_results[0].answer, expected_results[0].table_full,
                     expected_results[0].count, observed.answer, observed.table_full,
                     observed.count);
          mismatch_count++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    mode_i         = MODE_NOP;
    value_i        = '0;
    mismatch_count = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    shadow_stored = 0;
    shadow_zero   = 1'b0;
    shadow_limit  = 32'(LIMIT_RESET);
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_zero_and_extremes();
    test_probe_wrap();
    test_entry_limit();

    // fill to the 255-entry cap, then refusals and long probes at full load
    test_random_phase(320, 8'd255, 0, 0, 92, 0, 15);
    // small limit, sender idles often
    test_random_phase(80, 8'($urandom_range(2, 12)), 75, 0, 50, 3, 45);
    // single entry allowed, receiver stalls often
    test_random_phase(80, 8'd1, 0, 75, 50, 3, 45);
    // mid-range limit, both sides idle now and then
    test_random_phase(80, 8'($urandom_range(13, 254)), 25, 25, 55, 3, 45);

    wait_idle();
    stall_pct = 0;
    // longest probe is a full lap, so allow a little more than that
    repeat (600) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
